### rtl/core/lca_pkg.sv
// Package for the binary-lifting lowest common ancestor block.
// Holds size constants, command codes and the sequencer state type.
package lca_pkg;
    localparam int NODE_SLOTS_DEF  = 1024;
    localparam int LIFT_LEVELS_DEF = 10;
    localparam int NODE_W          = 10;
    localparam int CMD_W           = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_EDGE  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR,
        ST_BFS_POP,
        ST_BFS_EDGE,
        ST_BFS_EDGE_W,
        ST_BFS_NB,
        ST_BFS_NB_W,
        ST_BFS_NB2,
        ST_BFS_NB2_W,
        ST_LIFT_RD,
        ST_LIFT_RD_W,
        ST_LIFT_RD2,
        ST_LIFT_RD2_W,
        ST_Q_DEP,
        ST_Q_DEP_W,
        ST_Q_UP_RD,
        ST_Q_UP_RD_W,
        ST_Q_UP_DEP,
        ST_Q_UP_DEP_W,
        ST_Q_EQ,
        ST_Q_BOTH,
        ST_Q_BOTH_W,
        ST_Q_BOTH_B,
        ST_Q_BOTH_B_W,
        ST_Q_FIN,
        ST_Q_FIN_W,
        ST_DONE
    } t_state;
endpackage

### rtl/core/lca_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module lca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### rtl/core/lowest_common_ancestor_binary_lifting.sv
// Lowest common ancestor by binary lifting, sequenced over single-port RAMs.
// An edge transfer is taken in idle with busy low. A query before any build goes straight to
// its result; else it lifts the deeper node to the depth of the other, stops if the two meet,
// else lifts both together; each lifting step waits on two registered RAM reads in turn.
// A build clears all NODE_SLOTS*LIFT_LEVELS ancestor entries, visits each node reached along
// its edges, fills the upper ancestor levels and shows a result; synchronous reset clears control.
module lowest_common_ancestor_binary_lifting
    import lca_pkg::*;
#(
    parameter int NODE_SLOTS  = NODE_SLOTS_DEF,
    parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic              i_cfg_we,
    input  logic [NODE_W-1:0] i_cfg_wdata,
    output logic              o_result_valid,
    output logic              o_result_kind,
    output logic [NODE_W-1:0] o_ancestor_node
);
    // Node indexes inside the block cover the slot count; levels index the
    // flat ancestor RAM, which holds LIFT_LEVELS rows of NODE_SLOTS entries.
    localparam int NA_W  = $clog2(NODE_SLOTS);
    localparam int LV_W  = $clog2(LIFT_LEVELS);
    localparam int AN_D  = NODE_SLOTS * LIFT_LEVELS;
    localparam int AN_W  = $clog2(AN_D);
    localparam int ED_D  = NODE_SLOTS - 2;
    localparam int ED_W  = $clog2(ED_D + 1);
    localparam int EA_W  = $clog2(ED_D);
    localparam int DP_W  = NA_W + 1;

    t_state r_state, n_state;

    logic [NODE_W-1:0] r_node_count;
    logic [ED_W-1:0]   r_edge_cnt;
    logic              r_ready;

    // Working registers shared by build and query.
    logic [NA_W:0]     r_head, r_tail;
    logic [NA_W-1:0]   r_now, r_a, r_b, r_i, r_tmp;
    logic [DP_W-1:0]   r_now_dep, r_dep_b;
    logic [ED_W-1:0]   r_e;
    logic [LV_W-1:0]   r_k;
    logic [NA_W-1:0]   r_nb;
    logic [AN_W-1:0]   r_clr;

    // RAM ports.
    logic            ef_we, es_we, dp_we, an_we, vq_we;
    logic [EA_W-1:0] ed_addr;
    logic [NA_W-1:0] dp_addr, vq_addr;
    logic [AN_W-1:0] an_addr;
    logic [NODE_W-1:0] ef_rd, es_rd;
    logic [DP_W-1:0]   dp_wd, dp_rd;
    logic [NA_W-1:0]   an_wd, an_rd, vq_wd, vq_rd;

    lca_ram #(.WIDTH(NODE_W), .DEPTH(ED_D)) u_ef (
        .i_clk(i_clk), .i_we(ef_we), .i_addr(ed_addr), .i_wdata(i_node_a), .o_rdata(ef_rd));
    lca_ram #(.WIDTH(NODE_W), .DEPTH(ED_D)) u_es (
        .i_clk(i_clk), .i_we(es_we), .i_addr(ed_addr), .i_wdata(i_node_b), .o_rdata(es_rd));
    lca_ram #(.WIDTH(DP_W), .DEPTH(NODE_SLOTS)) u_dp (
        .i_clk(i_clk), .i_we(dp_we), .i_addr(dp_addr), .i_wdata(dp_wd), .o_rdata(dp_rd));
    lca_ram #(.WIDTH(NA_W), .DEPTH(AN_D)) u_an (
        .i_clk(i_clk), .i_we(an_we), .i_addr(an_addr), .i_wdata(an_wd), .o_rdata(an_rd));
    lca_ram #(.WIDTH(NA_W), .DEPTH(NODE_SLOTS)) u_vq (
        .i_clk(i_clk), .i_we(vq_we), .i_addr(vq_addr), .i_wdata(vq_wd), .o_rdata(vq_rd));

    // Nodes at or above the slot count act as the sentinel.
    function automatic logic [NA_W-1:0] clip(input logic [NODE_W-1:0] v);
        logic [NA_W-1:0] r;
        if (32'(v) >= NODE_SLOTS) begin
            r = '0;
        end else begin
            r = NA_W'(v);
        end
        return r;
    endfunction

    function automatic logic [AN_W-1:0] an_ix(input logic [LV_W-1:0] k,
                                             input logic [NA_W-1:0] n);
        return AN_W'(AN_W'(k) * AN_W'(NODE_SLOTS) + AN_W'(n));
    endfunction

    logic            accept;
    logic [NA_W-1:0] last_node;
    logic [NA_W-1:0] ef_c, es_c;
    logic            edge_last;

    assign accept    = start && !busy;
    assign busy      = (r_state != ST_IDLE);
    assign ef_c      = clip(ef_rd);
    assign es_c      = clip(es_rd);
    assign edge_last = (r_e + 1'b1 >= r_edge_cnt);
    // The table fill covers nodes 1 to node_count, bounded by the top slot.
    assign last_node = (32'(r_node_count) > NODE_SLOTS - 1) ?
                       NA_W'(NODE_SLOTS - 1) : NA_W'(r_node_count);

    // Registers and the datapath steps of the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_node_count <= NODE_W'(1);
            r_edge_cnt   <= '0;
            r_ready      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && t_cmd'(i_cmd) == CMD_EDGE && r_edge_cnt < ED_W'(ED_D)) begin
                        r_edge_cnt <= r_edge_cnt + 1'b1;
                    end
                    r_clr <= '0;
                    r_a   <= clip(i_node_a);
                    r_b   <= clip(i_node_b);
                    r_k   <= LV_W'(LIFT_LEVELS - 1);
                end
                ST_CLR: begin
                    r_clr  <= r_clr + 1'b1;
                    r_head <= '0;
                    r_tail <= (NA_W+1)'(1);
                end
                ST_BFS_POP: begin
                    r_e <= '0;
                    r_i <= NA_W'(1);
                    r_k <= LV_W'(1);
                    // Once the queue runs dry the tables count as built.
                    if (!(r_head < r_tail)) begin
                        r_ready <= 1'b1;
                    end
                end
                ST_BFS_EDGE: begin
                    r_now <= vq_rd;
                    r_head <= r_head + 1'b1;
                end
                ST_BFS_EDGE_W: begin
                    r_now_dep <= dp_rd;
                end
                ST_BFS_NB: begin
                    r_nb   <= es_c;
                end
                ST_BFS_NB_W: begin
                    if (ef_c == r_now && r_nb != '0 && dp_rd == '0 &&
                        r_tail < (NA_W+1)'(NODE_SLOTS)) begin
                        r_tail <= r_tail + 1'b1;
                    end
                    r_nb <= ef_c;
                end
                ST_BFS_NB2: ;
                ST_BFS_NB2_W: begin
                    if (es_c == r_now && r_nb != '0 && dp_rd == '0 &&
                        r_tail < (NA_W+1)'(NODE_SLOTS)) begin
                        r_tail <= r_tail + 1'b1;
                    end
                    r_e <= r_e + 1'b1;
                end
                ST_LIFT_RD: ;
                ST_LIFT_RD_W: begin
                    r_tmp <= an_rd;
                end
                ST_LIFT_RD2: ;
                ST_LIFT_RD2_W: begin
                    if (r_i == last_node) begin
                        r_i <= NA_W'(1);
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_Q_DEP: begin
                    // The depth of a was read at the command transfer.
                    r_now_dep <= dp_rd;
                end
                ST_Q_DEP_W: begin
                    // The depth of b arrives now; the deeper node becomes a.
                    if (r_now_dep < dp_rd) begin
                        r_dep_b <= r_now_dep;
                        r_a     <= r_b;
                        r_b     <= r_a;
                    end else begin
                        r_dep_b <= dp_rd;
                    end
                end
                ST_Q_UP_RD: ;
                ST_Q_UP_RD_W: begin
                    r_tmp <= an_rd;
                end
                ST_Q_UP_DEP: ;
                ST_Q_UP_DEP_W: begin
                    if (dp_rd >= r_dep_b) begin
                        r_a <= r_tmp;
                    end
                    if (r_k != '0) begin
                        r_k <= r_k - 1'b1;
                    end
                end
                ST_Q_EQ: begin
                    r_k <= LV_W'(LIFT_LEVELS - 1);
                end
                ST_Q_BOTH: ;
                ST_Q_BOTH_W: begin
                    r_tmp <= an_rd;
                end
                ST_Q_BOTH_B: ;
                ST_Q_BOTH_B_W: begin
                    if (an_rd != r_tmp) begin
                        r_a <= r_tmp;
                        r_b <= an_rd;
                    end
                    if (r_k != '0) begin
                        r_k <= r_k - 1'b1;
                    end
                end
                ST_Q_FIN: ;
                ST_Q_FIN_W: begin
                    r_a <= an_rd;
                end
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_BUILD: n_state = ST_CLR;
                        CMD_QUERY: n_state = r_ready ? ST_Q_DEP : ST_DONE;
                        CMD_EDGE,
                        CMD_NONE:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLR:        n_state = (r_clr == AN_W'(AN_D - 1)) ? ST_BFS_POP : ST_CLR;
            ST_BFS_POP:    n_state = (r_head < r_tail) ? ST_BFS_EDGE :
                                     (last_node == '0) ? ST_DONE : ST_LIFT_RD;
            ST_BFS_EDGE:   n_state = ST_BFS_EDGE_W;
            ST_BFS_EDGE_W: n_state = (r_edge_cnt == '0) ? ST_BFS_POP : ST_BFS_NB;
            ST_BFS_NB:     n_state = ST_BFS_NB_W;
            ST_BFS_NB_W:   n_state = ST_BFS_NB2;
            ST_BFS_NB2:    n_state = ST_BFS_NB2_W;
            ST_BFS_NB2_W:  n_state = edge_last ? ST_BFS_POP : ST_BFS_NB;
            ST_LIFT_RD:    n_state = (LIFT_LEVELS < 2) ? ST_DONE : ST_LIFT_RD_W;
            ST_LIFT_RD_W:  n_state = ST_LIFT_RD2;
            ST_LIFT_RD2:   n_state = ST_LIFT_RD2_W;
            ST_LIFT_RD2_W: n_state = (r_k == LV_W'(LIFT_LEVELS - 1) && r_i == last_node) ?
                                     ST_DONE : ST_LIFT_RD;
            ST_Q_DEP:      n_state = ST_Q_DEP_W;
            ST_Q_DEP_W:    n_state = ST_Q_UP_RD;
            ST_Q_UP_RD:    n_state = ST_Q_UP_RD_W;
            ST_Q_UP_RD_W:  n_state = ST_Q_UP_DEP;
            ST_Q_UP_DEP:   n_state = ST_Q_UP_DEP_W;
            ST_Q_UP_DEP_W: n_state = (r_k == '0) ? ST_Q_EQ : ST_Q_UP_RD;
            ST_Q_EQ:       n_state = (r_a == r_b) ? ST_DONE : ST_Q_BOTH;
            ST_Q_BOTH:     n_state = ST_Q_BOTH_W;
            ST_Q_BOTH_W:   n_state = ST_Q_BOTH_B;
            ST_Q_BOTH_B:   n_state = ST_Q_BOTH_B_W;
            ST_Q_BOTH_B_W: n_state = (r_k == '0) ? ST_Q_FIN : ST_Q_BOTH;
            ST_Q_FIN:      n_state = ST_Q_FIN_W;
            ST_Q_FIN_W:    n_state = ST_DONE;
            ST_DONE:       n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // RAM controls and result outputs.
    always_comb begin
        ef_we = 1'b0;
        es_we = 1'b0;
        dp_we = 1'b0;
        an_we = 1'b0;
        vq_we = 1'b0;
        ed_addr = EA_W'(r_e);
        dp_addr = r_nb;
        dp_wd   = '0;
        an_addr = an_ix(r_k, r_i);
        an_wd   = '0;
        vq_addr = NA_W'(r_head);
        vq_wd   = r_nb;
        unique case (r_state)
            ST_IDLE: begin
                ed_addr = EA_W'(r_edge_cnt);
                if (accept && t_cmd'(i_cmd) == CMD_EDGE && r_edge_cnt < ED_W'(ED_D)) begin
                    ef_we = 1'b1;
                    es_we = 1'b1;
                end
                dp_addr = clip(i_node_a);
            end
            ST_CLR: begin
                // Sweep every entry of the ancestor table and of the depth table; the root
                // gets depth one and heads the visit queue.
                dp_we   = (r_clr < AN_W'(NODE_SLOTS));
                dp_addr = NA_W'(r_clr);
                dp_wd   = (r_clr == AN_W'(1)) ? DP_W'(1) : '0;
                an_we   = 1'b1;
                an_addr = r_clr;
                vq_we   = (r_clr == '0);
                vq_addr = '0;
                vq_wd   = NA_W'(1);
            end
            ST_BFS_EDGE:   dp_addr = vq_rd;
            ST_BFS_EDGE_W: ed_addr = '0;
            ST_BFS_NB:     dp_addr = es_c;
            ST_BFS_NB_W: begin
                if (ef_c == r_now && r_nb != '0 && dp_rd == '0 &&
                    r_tail < (NA_W+1)'(NODE_SLOTS)) begin
                    dp_we   = 1'b1;
                    dp_wd   = r_now_dep + 1'b1;
                    an_we   = 1'b1;
                    an_addr = an_ix('0, r_nb);
                    an_wd   = r_now;
                    vq_we   = 1'b1;
                    vq_addr = NA_W'(r_tail);
                end
            end
            ST_BFS_NB2:    dp_addr = r_nb;
            ST_BFS_NB2_W: begin
                ed_addr = EA_W'(r_e + 1'b1);
                if (es_c == r_now && r_nb != '0 && dp_rd == '0 &&
                    r_tail < (NA_W+1)'(NODE_SLOTS)) begin
                    dp_we   = 1'b1;
                    dp_wd   = r_now_dep + 1'b1;
                    an_we   = 1'b1;
                    an_addr = an_ix('0, r_nb);
                    an_wd   = r_now;
                    vq_we   = 1'b1;
                    vq_addr = NA_W'(r_tail);
                end
            end
            ST_LIFT_RD:    an_addr = an_ix(r_k - 1'b1, r_i);
            ST_LIFT_RD_W:  an_addr = an_ix(r_k - 1'b1, an_rd);
            ST_LIFT_RD2:   an_addr = an_ix(r_k - 1'b1, r_tmp);
            ST_LIFT_RD2_W: begin
                an_we   = 1'b1;
                an_addr = an_ix(r_k, r_i);
                an_wd   = an_rd;
            end
            ST_Q_DEP:      dp_addr = r_b;
            ST_Q_UP_RD:    an_addr = an_ix(r_k, r_a);
            ST_Q_UP_RD_W:  an_addr = an_ix(r_k, r_a);
            ST_Q_UP_DEP:   dp_addr = r_tmp;
            ST_Q_BOTH:     an_addr = an_ix(r_k, r_a);
            ST_Q_BOTH_W:   an_addr = an_ix(r_k, r_a);
            ST_Q_BOTH_B:   an_addr = an_ix(r_k, r_b);
            ST_Q_FIN:      an_addr = an_ix('0, r_a);
            ST_Q_FIN_W:    an_addr = an_ix('0, r_a);
            default: ;
        endcase
    end

    // A result appears for one cycle when the sequencer passes DONE.
    logic r_kind;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= 1'b0;
        end else if (accept) begin
            r_kind <= (t_cmd'(i_cmd) == CMD_QUERY);
        end
    end

    assign o_result_valid  = (r_state == ST_DONE);
    assign o_result_kind   = r_kind;
    assign o_ancestor_node = (r_kind && r_ready) ? NODE_W'(r_a) : '0;

    // A result is only ever shown after a command was taken.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(busy) || $past(start)))
        else $error("result without a command in flight");
    // The edge count never runs backwards.
    a_edge_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_edge_cnt >= $past(r_edge_cnt))
        else $error("edge count decreased");
    // A build result always reports the build kind and node zero.
    a_build_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result_kind) |-> o_ancestor_node == '0)
        else $error("build result carries a node");
endmodule
